FILE: hw/rtl/assert_macros.svh
// assertion macros shared by the keyer rtl
// expects clk, and rst_n for IMK_ASSERT, in the scope of every use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define IMK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define IMK_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IMK_ASSERT(lbl, prop, msg)
`define IMK_ASSERT_RST(lbl, prop, msg)
`endif

`endif

FILE: hw/rtl/imk_pkg.sv
// shared types, register codes and the dot length table of the keyer
// no dependencies
`timescale 1ns / 1ps

package imk_pkg;

  localparam int unsigned DOT_W  = 11;
  localparam int unsigned DASH_W = 13;
  localparam int unsigned MS_W   = 13;

  // register indexes, byte address is 4 * index
  localparam logic [2:0] REG_MODE    = 3'd0;
  localparam logic [2:0] REG_SPEED   = 3'd1;
  localparam logic [2:0] REG_WEIGHT  = 3'd2;
  localparam logic [2:0] REG_LSPACE  = 3'd3;
  localparam logic [2:0] REG_SWAPPED = 3'd4;

  localparam logic [1:0] MODE_STRAIGHT = 2'd0;
  localparam logic [1:0] MODE_IAMBIC_A = 2'd1;
  localparam logic [1:0] MODE_IAMBIC_B = 2'd2;

  typedef struct packed {
    logic              action;
    logic              paddle_channel;
    logic              paddle_level;
  } imk_item_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic              letter_space_on;
    logic              paddles_swapped;
    logic [DOT_W-1:0]  dot_ms;
    logic [DASH_W-1:0] dash_ms;
  } imk_cfg_t;

  // 1200 / wpm for wpm 1..100, indexed by wpm - 1
  localparam logic [DOT_W-1:0] DOT_MS_TBL [0:99] = '{
    11'd1200, 11'd600, 11'd400, 11'd300, 11'd240, 11'd200, 11'd171, 11'd150, 11'd133, 11'd120,
    11'd109,  11'd100, 11'd92,  11'd85,  11'd80,  11'd75,  11'd70,  11'd66,  11'd63,  11'd60,
    11'd57,   11'd54,  11'd52,  11'd50,  11'd48,  11'd46,  11'd44,  11'd42,  11'd41,  11'd40,
    11'd38,   11'd37,  11'd36,  11'd35,  11'd34,  11'd33,  11'd32,  11'd31,  11'd30,  11'd30,
    11'd29,   11'd28,  11'd27,  11'd27,  11'd26,  11'd26,  11'd25,  11'd25,  11'd24,  11'd24,
    11'd23,   11'd23,  11'd22,  11'd22,  11'd21,  11'd21,  11'd21,  11'd20,  11'd20,  11'd20,
    11'd19,   11'd19,  11'd19,  11'd18,  11'd18,  11'd18,  11'd17,  11'd17,  11'd17,  11'd17,
    11'd16,   11'd16,  11'd16,  11'd16,  11'd16,  11'd15,  11'd15,  11'd15,  11'd15,  11'd15,
    11'd14,   11'd14,  11'd14,  11'd14,  11'd14,  11'd13,  11'd13,  11'd13,  11'd13,  11'd13,
    11'd13,   11'd13,  11'd12,  11'd12,  11'd12,  11'd12,  11'd12,  11'd12,  11'd12,  11'd12
  };

endpackage

FILE: hw/rtl/imk_in_if.sv
// paddle and tick input channel
// no dependencies
`timescale 1ns / 1ps

interface imk_in_if;
  logic valid;
  logic ready;
  logic action;
  logic paddle_channel;
  logic paddle_level;

  modport source (output valid, output action, output paddle_channel, output paddle_level,
                  input ready);
  modport sink   (input valid, input action, input paddle_channel, input paddle_level,
                  output ready);
endinterface

FILE: hw/rtl/imk_out_if.sv
// key level result channel
// no dependencies
`timescale 1ns / 1ps

interface imk_out_if;
  logic valid;
  logic ready;
  logic key_on;

  modport source (output valid, output key_on, input ready);
  modport sink   (input valid, input key_on, output ready);
endinterface

FILE: hw/rtl/imk_len.sv
// dot and dash length unit, recomputed after a speed or weight write
// depends on imk_pkg
`timescale 1ns / 1ps

module imk_len (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [6:0]                 speed_wpm,
  input  logic [6:0]                 dash_weight,
  output logic                       busy,
  output logic [imk_pkg::DOT_W-1:0]  dot_ms,
  output logic [imk_pkg::DASH_W-1:0] dash_ms
);
  import imk_pkg::*;

  // floor(y / 25) = (y * RECIP25) >> 23, exact for 18 bit y
  localparam logic [18:0] RECIP25 = 19'd335545;

  logic              start_r;
  logic              st2_r;
  logic [DOT_W-1:0]  dot_ms_r;
  logic [18:0]       prod_r;
  logic [DASH_W-1:0] dash_ms_r;

  logic [6:0]  speed_cl;
  logic [6:0]  weight_cl;
  logic [8:0]  weight3;
  logic [DOT_W-1:0] dot_lookup;
  logic [19:0] prod_nxt;
  logic [36:0] recip_prod;

  always_comb begin
    speed_cl = speed_wpm;
    if (speed_cl < 7'd1) speed_cl = 7'd1;
    if (speed_cl > 7'd100) speed_cl = 7'd100;
    weight_cl = dash_weight;
    if (weight_cl < 7'd10) weight_cl = 7'd10;
    if (weight_cl > 7'd90) weight_cl = 7'd90;
  end

  assign weight3    = {2'b00, weight_cl} * 9'd3;
  assign dot_lookup = DOT_MS_TBL[speed_cl - 7'd1];
  assign prod_nxt   = {9'd0, dot_lookup} * {11'd0, weight3};
  // divide by 50 as a halving then a divide by 25
  assign recip_prod = {19'd0, prod_r[18:1]} * {18'd0, RECIP25};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r   <= 1'b0;
      st2_r     <= 1'b0;
      dot_ms_r  <= DOT_W'(60);
      prod_r    <= 19'd9000;
      dash_ms_r <= DASH_W'(180);
    end else begin
      start_r <= start;
      st2_r   <= start_r;
      if (start_r) begin
        dot_ms_r <= dot_lookup;
        prod_r   <= prod_nxt[18:0];
      end
      if (st2_r) begin
        dash_ms_r <= recip_prod[35:23];
      end
    end
  end

  assign busy    = start_r;
  assign dot_ms  = dot_ms_r;
  assign dash_ms = dash_ms_r;

endmodule

FILE: hw/rtl/imk_core.sv
// keyer state machine: paddle lines, element memories, phase and ms timer
// depends on imk_pkg and assert_macros.svh
`timescale 1ns / 1ps

module imk_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  imk_pkg::imk_item_t  item,
  input  imk_pkg::imk_cfg_t   cfg,
  output logic                key_nxt
);
  import imk_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_STRAIGHT = 3'd1,
    PH_DOT      = 3'd2,
    PH_DOT_GAP  = 3'd3,
    PH_DASH     = 3'd4,
    PH_DASH_GAP = 3'd5,
    PH_SPACE    = 3'd6
  } phase_t;

  phase_t          phase_r, phase_nxt;
  logic [MS_W-1:0] ms_left_r, ms_left_nxt;
  logic            left_line_r, left_line_nxt;
  logic            right_line_r, right_line_nxt;
  logic            dot_mem_r, dot_mem_nxt;
  logic            dash_mem_r, dash_mem_nxt;
  logic            dot_sq_r, dot_sq_nxt;
  logic            dash_sq_r, dash_sq_nxt;

  logic [MS_W-1:0] dot_len;
  logic [MS_W-1:0] dash_len;
  logic [MS_W-1:0] space_len;

  assign dot_len   = {{(MS_W-DOT_W){1'b0}}, cfg.dot_ms};
  assign dash_len  = cfg.dash_ms;
  assign space_len = {{(MS_W-DOT_W-1){1'b0}}, cfg.dot_ms, 1'b0};

  always_comb begin
    phase_t          ph;
    logic [MS_W-1:0] ms;
    logic            ll, rl, dm, dam, dsq, dasq, dl, dhl;

    ph   = (phase_r > PH_SPACE) ? PH_IDLE : phase_r;
    ms   = ms_left_r;
    ll   = left_line_r;
    rl   = right_line_r;
    dm   = dot_mem_r;
    dam  = dash_mem_r;
    dsq  = dot_sq_r;
    dasq = dash_sq_r;

    if (!item.action) begin
      if (item.paddle_channel) begin
        ll = item.paddle_level;
        if (item.paddle_level) begin
          if (cfg.paddles_swapped) dam = 1'b1;
          else dm = 1'b1;
        end
      end else begin
        rl = item.paddle_level;
        if (item.paddle_level) begin
          if (cfg.paddles_swapped) dm = 1'b1;
          else dam = 1'b1;
        end
      end
    end

    dl  = cfg.paddles_swapped ? rl : ll;
    dhl = cfg.paddles_swapped ? ll : rl;

    if (item.action) begin
      if (ph != PH_IDLE && ph != PH_STRAIGHT && ms != '0) ms = ms - MS_W'(1);
      unique case (ph)
        PH_DOT: begin
          if (dhl) dam = 1'b1;
          if (ms == '0) begin
            ph = PH_DOT_GAP;
            ms = dot_len;
          end
        end
        PH_DASH: begin
          if (dl) dm = 1'b1;
          if (ms == '0) begin
            ph = PH_DASH_GAP;
            ms = dot_len;
          end
        end
        PH_DOT_GAP: begin
          if (dl) dm = 1'b1;
          if (dhl) dam = 1'b1;
          if (ms == '0) begin
            if (cfg.mode == MODE_STRAIGHT) begin
              if (dl) begin
                dm = 1'b0; dasq = dhl; ph = PH_DOT; ms = dot_len;
              end else begin
                ph = PH_IDLE;
              end
            end else begin
              if (cfg.mode == MODE_IAMBIC_A && !dl && !dhl) dasq = 1'b0;
              if (dam || dhl || dasq) begin
                dasq = 1'b0;
                dam = 1'b0; dsq = dl; ph = PH_DASH; ms = dash_len;
              end else if (dl || dm) begin
                dm = 1'b0; dasq = dhl; ph = PH_DOT; ms = dot_len;
              end else if (cfg.letter_space_on) begin
                dm = 1'b0; dam = 1'b0; ph = PH_SPACE; ms = space_len;
              end else begin
                ph = PH_IDLE;
              end
            end
          end
        end
        PH_DASH_GAP: begin
          if (dl) dm = 1'b1;
          if (dhl) dam = 1'b1;
          if (ms == '0) begin
            // mode A drops the squeeze when both paddles are open
            if (cfg.mode == MODE_IAMBIC_A && !dl && !dhl) dsq = 1'b0;
            if (dm || dl || dsq) begin
              dsq = 1'b0;
              dm = 1'b0; dasq = dhl; ph = PH_DOT; ms = dot_len;
            end else if (dhl || dam) begin
              dam = 1'b0; dsq = dl; ph = PH_DASH; ms = dash_len;
            end else if (cfg.letter_space_on) begin
              dm = 1'b0; dam = 1'b0; ph = PH_SPACE; ms = space_len;
            end else begin
              ph = PH_IDLE;
            end
          end
        end
        PH_SPACE: begin
          if (dl) dm = 1'b1;
          if (dhl) dam = 1'b1;
          if (ms == '0) begin
            if (dm || dl) begin
              dm = 1'b0; dasq = dhl; ph = PH_DOT; ms = dot_len;
            end else if (dam || dhl) begin
              dam = 1'b0; dsq = dl; ph = PH_DASH; ms = dash_len;
            end else begin
              ph = PH_IDLE;
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (ph == PH_STRAIGHT && !dhl) begin
      if (dl) begin
        dm = 1'b0; dasq = dhl; ph = PH_DOT; ms = dot_len;
      end else begin
        ph = PH_IDLE;
      end
    end

    if (ph == PH_IDLE) begin
      if (cfg.mode == MODE_STRAIGHT) begin
        if (dhl) begin
          ph = PH_STRAIGHT;
        end else if (dl) begin
          dm = 1'b0; dasq = dhl; ph = PH_DOT; ms = dot_len;
        end
      end else begin
        if (dm || dl) begin
          dm = 1'b0; dasq = dhl; ph = PH_DOT; ms = dot_len;
        end else if (dam || dhl) begin
          dam = 1'b0; dsq = dl; ph = PH_DASH; ms = dash_len;
        end
      end
    end

    phase_nxt      = ph;
    ms_left_nxt    = ms;
    left_line_nxt  = ll;
    right_line_nxt = rl;
    dot_mem_nxt    = dm;
    dash_mem_nxt   = dam;
    dot_sq_nxt     = dsq;
    dash_sq_nxt    = dasq;
    key_nxt        = (ph == PH_STRAIGHT) || (ph == PH_DOT) || (ph == PH_DASH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      ms_left_r    <= '0;
      left_line_r  <= 1'b0;
      right_line_r <= 1'b0;
      dot_mem_r    <= 1'b0;
      dash_mem_r   <= 1'b0;
      dot_sq_r     <= 1'b0;
      dash_sq_r    <= 1'b0;
    end else if (step_en) begin
      phase_r      <= phase_nxt;
      ms_left_r    <= ms_left_nxt;
      left_line_r  <= left_line_nxt;
      right_line_r <= right_line_nxt;
      dot_mem_r    <= dot_mem_nxt;
      dash_mem_r   <= dash_mem_nxt;
      dot_sq_r     <= dot_sq_nxt;
      dash_sq_r    <= dash_sq_nxt;
    end
  end

  `IMK_ASSERT_RST(a_reset_idle, !rst_n |=> phase_r == PH_IDLE, "phase not idle after reset")
  `IMK_ASSERT(a_timed_nonzero,
    (phase_r != PH_IDLE && phase_r != PH_STRAIGHT) |-> ms_left_r != '0,
    "timed phase with an expired timer")
  `IMK_ASSERT(a_hold_no_step,
    !step_en |=> $stable(phase_r) && $stable(ms_left_r) && $stable(dot_mem_r),
    "state moved without a beat")
  `IMK_ASSERT(a_tick_keeps_lines,
    step_en && item.action |=> $stable(left_line_r) && $stable(right_line_r),
    "tick changed a paddle line")

endmodule

FILE: hw/rtl/iambic_morse_keyer.sv
// iambic morse keyer top level: input register, keyer core, result register
// a held beat steps the core and its key level goes to the result register
// throughput: one beat per cycle unless the output or length unit stalls
// a speed or weight write holds off input while the length unit is busy
// synchronous active-low reset resets control state, not the item or key data
`timescale 1ns / 1ps

module iambic_morse_keyer (
  input  logic        clk,
  input  logic        rst_n,
  imk_in_if.sink      in_ch,
  imk_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import imk_pkg::*;

  logic [1:0] mode_r;
  logic [6:0] speed_r;
  logic [6:0] weight_r;
  logic       lspace_r;
  logic       swapped_r;

  logic       cfg_wr;
  logic [2:0] cfg_idx;
  logic       len_start;
  logic       len_busy;
  logic [DOT_W-1:0]  dot_ms;
  logic [DASH_W-1:0] dash_ms;

  logic       in_valid_r;
  imk_item_t  item_r;
  logic       out_valid_r;
  logic       key_r;
  logic       advance;
  logic       key_nxt;
  imk_cfg_t   core_cfg;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[4:2];
  assign len_start  = cfg_wr && (cfg_idx == REG_SPEED || cfg_idx == REG_WEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_IAMBIC_B;
      speed_r   <= 7'd20;
      weight_r  <= 7'd50;
      lspace_r  <= 1'b0;
      swapped_r <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MODE:    mode_r    <= cfg_pwdata[1:0];
        REG_SPEED:   speed_r   <= cfg_pwdata[6:0];
        REG_WEIGHT:  weight_r  <= cfg_pwdata[6:0];
        REG_LSPACE:  lspace_r  <= cfg_pwdata[0];
        REG_SWAPPED: swapped_r <= cfg_pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_MODE:    cfg_prdata = {30'd0, mode_r};
      REG_SPEED:   cfg_prdata = {25'd0, speed_r};
      REG_WEIGHT:  cfg_prdata = {25'd0, weight_r};
      REG_LSPACE:  cfg_prdata = {31'd0, lspace_r};
      REG_SWAPPED: cfg_prdata = {31'd0, swapped_r};
      default:     cfg_prdata = 32'd0;
    endcase
  end

  imk_len u_len (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (len_start),
    .speed_wpm   (speed_r),
    .dash_weight (weight_r),
    .busy        (len_busy),
    .dot_ms      (dot_ms),
    .dash_ms     (dash_ms)
  );

  assign core_cfg.mode            = mode_r;
  assign core_cfg.letter_space_on = lspace_r;
  assign core_cfg.paddles_swapped = swapped_r;
  assign core_cfg.dot_ms          = dot_ms;
  assign core_cfg.dash_ms         = dash_ms;

  // the held beat steps the core when the result register can take it
  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !len_busy && (!in_valid_r || advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) in_valid_r <= 1'b1;
      else if (advance) in_valid_r <= 1'b0;
      if (advance) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.action         <= in_ch.action;
      item_r.paddle_channel <= in_ch.paddle_channel;
      item_r.paddle_level   <= in_ch.paddle_level;
    end
    if (advance) key_r <= key_nxt;
  end

  imk_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (item_r),
    .cfg     (core_cfg),
    .key_nxt (key_nxt)
  );

  assign out_ch.valid  = out_valid_r;
  assign out_ch.key_on = key_r;

endmodule
